[design/mxt_pkg.sv]
package mxt_pkg;

    // sequencer states of the trie walker
    typedef enum logic [2:0] {
        S_IDLE,
        S_QUERY,
        S_INSERT,
        S_ALLOC,
        S_LEAF,
        S_DONE
    } t_state;

endpackage

[design/mxt_ram.sv]
module mxt_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/max_xor_pair_trie.sv]
// Running maximum XOR of any two values of a set, kept in a binary trie. Each request
// carries a value (tdata) and a start-of-set flag (tuser); each request yields one
// result with the running maximum (tdata) and a sticky pool overflow flag (tuser).
// The trie lives in a node memory of NODE_POOL entries with a registered read; the root
// node sits in flops, so a new set needs no clearing pass. A request is taken, then the
// query walk visits up to VALUE_BITS levels and the insert walk up to VALUE_BITS levels
// (following existing nodes, then writing one new node per level); then a new leaf node
// is written and the result is handed over to the output register. The node memory port
// visits one trie level per cycle. The first value of a set and a value arriving to an
// empty trie skip the query walk. When the nodes a value needs do not all fit, the insert
// is dropped and the overflow flag stays set until the next set starts. The input side is
// accepting again while a finished result still waits at the output register.
module max_xor_pair_trie #(
    parameter int VALUE_BITS = 21,
    parameter int NODE_POOL  = 32768
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave side
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]       i_s_axis_tdata,  // value
    input  logic                                  i_s_axis_tuser,  // start_set
    // master side
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [((VALUE_BITS+7)/8)*8-1:0]       o_m_axis_tdata,  // max_xor
    output logic                                  o_m_axis_tuser   // overflow
);

    import mxt_pkg::*;

    localparam int DATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int IDX_W  = $clog2(NODE_POOL);
    localparam int NF_W   = $clog2(NODE_POOL + 1);
    localparam int CNT_W  = NF_W + 1;
    localparam int LVL_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int ENT_W  = 2 * IDX_W;

    // state
    t_state                 r_state, n_state;
    logic [VALUE_BITS-1:0]  r_value, n_value;
    logic [LVL_W-1:0]       r_lvl, n_lvl;
    logic [IDX_W-1:0]       r_node, n_node;
    logic                   r_at_root, n_at_root;
    logic [VALUE_BITS-1:0]  r_acc, n_acc;
    logic [VALUE_BITS-1:0]  r_best, n_best;
    logic                   r_ovf, n_ovf;
    logic [IDX_W-1:0]       r_root0, n_root0;
    logic [IDX_W-1:0]       r_root1, n_root1;
    logic [NF_W-1:0]        r_nf, n_nf;
    logic                   r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0]  r_out_max, n_out_max;
    logic                   r_out_ovf, n_out_ovf;

    // node memory port
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENT_W-1:0]       ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENT_W-1:0]       ram_rdata;

    // current node view
    logic [IDX_W-1:0]       e_c0, e_c1, alt, same, nxt;
    logic [IDX_W-1:0]       nf_idx, nf_next;
    logic                   bit_b;
    logic [VALUE_BITS-1:0]  lvl_mask;
    logic                   fits;

    mxt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NODE_POOL)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // child pointers of the node at the current level
    always_comb begin
        e_c0     = r_at_root ? r_root0 : ram_rdata[IDX_W-1:0];
        e_c1     = r_at_root ? r_root1 : ram_rdata[ENT_W-1:IDX_W];
        bit_b    = r_value[r_lvl];
        alt      = bit_b ? e_c0 : e_c1;
        same     = bit_b ? e_c1 : e_c0;
        nxt      = (alt != '0) ? alt : same;
        lvl_mask = {{(VALUE_BITS-1){1'b0}}, 1'b1} << r_lvl;
        nf_idx   = r_nf[IDX_W-1:0];
        nf_next  = nf_idx + IDX_W'(1);
        fits     = (CNT_W'(r_lvl) + CNT_W'(1) + CNT_W'(r_nf)) <= CNT_W'(NODE_POOL);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_root0     <= '0;
            r_root1     <= '0;
            r_nf        <= NF_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_best      <= n_best;
            r_ovf       <= n_ovf;
            r_root0     <= n_root0;
            r_root1     <= n_root1;
            r_nf        <= n_nf;
            r_out_valid <= n_out_valid;
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_lvl     <= n_lvl;
        r_node    <= n_node;
        r_at_root <= n_at_root;
        r_acc     <= n_acc;
        r_out_max <= n_out_max;
        r_out_ovf <= n_out_ovf;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_lvl       = r_lvl;
        n_node      = r_node;
        n_at_root   = r_at_root;
        n_acc       = r_acc;
        n_best      = r_best;
        n_ovf       = r_ovf;
        n_root0     = r_root0;
        n_root1     = r_root1;
        n_nf        = r_nf;
        n_out_valid = r_out_valid & ~i_m_axis_tready;
        n_out_max   = r_out_max;
        n_out_ovf   = r_out_ovf;
        ram_we      = 1'b0;
        ram_waddr   = r_node;
        ram_wdata   = '0;
        ram_raddr   = r_node;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_value   = i_s_axis_tdata[VALUE_BITS-1:0];
                    n_lvl     = LVL_W'(VALUE_BITS - 1);
                    n_at_root = 1'b1;
                    n_acc     = '0;
                    if (i_s_axis_tuser) begin
                        n_root0 = '0;
                        n_root1 = '0;
                        n_nf    = NF_W'(1);
                        n_best  = '0;
                        n_ovf   = 1'b0;
                        n_state = S_INSERT;
                    end else if (r_root0 == '0 && r_root1 == '0) begin
                        n_state = S_INSERT;
                    end else begin
                        n_state = S_QUERY;
                    end
                end
            end

            // prefer the opposite branch at each level
            S_QUERY: begin
                if (alt != '0) begin
                    n_acc = r_acc | lvl_mask;
                end
                if (r_lvl == '0 || nxt == '0) begin
                    if (n_acc > r_best) begin
                        n_best = n_acc;
                    end
                    n_lvl     = LVL_W'(VALUE_BITS - 1);
                    n_at_root = 1'b1;
                    n_state   = S_INSERT;
                end else begin
                    ram_raddr = nxt;
                    n_node    = nxt;
                    n_at_root = 1'b0;
                    n_lvl     = r_lvl - LVL_W'(1);
                end
            end

            // follow the existing path, then link the first new node
            S_INSERT: begin
                if (same != '0) begin
                    if (r_lvl == '0) begin
                        n_state = S_DONE;
                    end else begin
                        ram_raddr = same;
                        n_node    = same;
                        n_at_root = 1'b0;
                        n_lvl     = r_lvl - LVL_W'(1);
                    end
                end else if (!fits) begin
                    n_ovf   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    if (r_at_root) begin
                        if (bit_b) begin
                            n_root1 = nf_idx;
                        end else begin
                            n_root0 = nf_idx;
                        end
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_node;
                        ram_wdata = bit_b ? {nf_idx, e_c0} : {e_c1, nf_idx};
                    end
                    if (r_lvl == '0) begin
                        n_state = S_LEAF;
                    end else begin
                        n_lvl   = r_lvl - LVL_W'(1);
                        n_state = S_ALLOC;
                    end
                end
            end

            // fresh nodes, each pointing at the next one
            S_ALLOC: begin
                ram_we    = 1'b1;
                ram_waddr = nf_idx;
                ram_wdata = bit_b ? {nf_next, IDX_W'(0)} : {IDX_W'(0), nf_next};
                n_nf      = r_nf + NF_W'(1);
                if (r_lvl == '0) begin
                    n_state = S_LEAF;
                end else begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end

            S_LEAF: begin
                ram_we    = 1'b1;
                ram_waddr = nf_idx;
                ram_wdata = '0;
                n_nf      = r_nf + NF_W'(1);
                n_state   = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_max   = r_best;
                    n_out_ovf   = r_ovf;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = DATA_W'(r_out_max);
    assign o_m_axis_tuser  = r_out_ovf;

endmodule

[bench/max_xor_pair_trie_chk.sv]
`timescale 1ns / 1ps

module max_xor_pair_trie_chk #(
    parameter int VALUE_BITS = 21,
    parameter int NODE_POOL  = 32768
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_s_tvalid,
    input  logic                                  i_s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]       i_s_tdata,   // value
    input  logic                                  i_s_tuser,   // start_set
    // result channel
    input  logic                                  i_m_tvalid,
    input  logic                                  i_m_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]       i_m_tdata,   // max_xor
    input  logic                                  i_m_tuser,   // overflow
    output int                                    o_mismatches,
    output int                                    o_waiting
);

    typedef struct packed {
        logic [VALUE_BITS-1:0] max_xor;
        logic                  overflow;
    } t_xor_result;

    // shadow trie: two child links per node, 0 means no child
    bit [15:0]             child_of [0:NODE_POOL-1][0:1];
    int unsigned           next_node = 1;
    logic [VALUE_BITS-1:0] running_max = '0;
    logic                  pool_overflowed = 1'b0;
    t_xor_result           expected_q [$];
    int                    fail_count = 0;

    assign o_mismatches = fail_count;

    // one request: optional query walk, then an insert that is all or nothing
    function automatic void absorb_value(input logic [VALUE_BITS-1:0] v, input logic first);
        int unsigned           node;
        int unsigned           nxt;
        int unsigned           need;
        logic [VALUE_BITS-1:0] best;
        bit                    walking;
        t_xor_result           res;
        if (first) begin
            child_of[0][0] = 0;
            child_of[0][1] = 0;
            next_node = 1;
            running_max = '0;
            pool_overflowed = 1'b0;
        end else if (child_of[0][0] != 0 || child_of[0][1] != 0) begin
            // greedy walk toward the opposite bit at every level
            node = 0;
            best = '0;
            for (int i = VALUE_BITS - 1; i >= 0; i--) begin
                if (child_of[node][!v[i]] != 0) begin
                    best[i] = 1'b1;
                    node = child_of[node][!v[i]];
                end else begin
                    node = child_of[node][v[i]];
                end
                if (node == 0)
                    break;
            end
            if (best > running_max)
                running_max = best;
        end
        // nodes missing below the deepest existing prefix
        node = 0;
        need = 0;
        walking = 1'b1;
        for (int i = VALUE_BITS - 1; i >= 0; i--) begin
            if (walking) begin
                nxt = child_of[node][v[i]];
                if (nxt == 0)
                    walking = 1'b0;
                else
                    node = nxt;
            end
            if (!walking)
                need++;
        end
        if (need > NODE_POOL - next_node) begin
            pool_overflowed = 1'b1;
        end else begin
            node = 0;
            for (int i = VALUE_BITS - 1; i >= 0; i--) begin
                nxt = child_of[node][v[i]];
                if (nxt == 0) begin
                    nxt = next_node;
                    next_node++;
                    child_of[nxt][0] = 0;
                    child_of[nxt][1] = 0;
                    child_of[node][v[i]] = 16'(nxt);
                end
                node = nxt;
            end
        end
        res.max_xor = running_max;
        res.overflow = pool_overflowed;
        expected_q.push_back(res);
    endfunction

    // predict on each request, compare on each result
    always @(posedge i_clk) begin : watch_channels
        t_xor_result want;
        if (!i_rst_n) begin
            child_of[0][0] = 0;
            child_of[0][1] = 0;
            next_node = 1;
            running_max = '0;
            pool_overflowed = 1'b0;
            expected_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                absorb_value(i_s_tdata[VALUE_BITS-1:0], i_s_tuser);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result with nothing expected: max_xor %h overflow %b",
                                 $realtime, i_m_tdata[VALUE_BITS-1:0], i_m_tuser);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_m_tdata[VALUE_BITS-1:0] !== want.max_xor ||
                        i_m_tuser !== want.overflow) begin
                        if (fail_count < 10)
                            $display("%0t: mismatch: expected max_xor %h overflow %b, got %h %b",
                                     $realtime, want.max_xor, want.overflow,
                                     i_m_tdata[VALUE_BITS-1:0], i_m_tuser);
                        fail_count++;
                    end
                end
            end
        end
        o_waiting <= expected_q.size();
    end

endmodule

[bench/max_xor_pair_trie_tb.sv]
`timescale 1ns / 1ps

module max_xor_pair_trie_tb;

    localparam int VALUE_BITS   = 21;
    localparam int NODE_POOL    = 32768;
    localparam int DW           = ((VALUE_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1600;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DW-1:0]         s_tdata = '0;      // value
    logic                  s_tuser = 1'b0;    // start_set
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DW-1:0]         m_tdata;           // max_xor
    logic                  m_tuser;           // overflow
    bit                    idle_on = 1'b1;
    int                    mismatches;
    int                    waiting;
    int                    quiet_cycles = 0;
    int                    sent = 0;
    logic [VALUE_BITS-1:0] prev_val = '0;

    always #5 i_clk = ~i_clk;

    max_xor_pair_trie #(
        .VALUE_BITS (VALUE_BITS),
        .NODE_POOL  (NODE_POOL)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    max_xor_pair_trie_chk #(
        .VALUE_BITS (VALUE_BITS),
        .NODE_POOL  (NODE_POOL)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_mismatches (mismatches),
        .o_waiting    (waiting)
    );

    // result side back-pressure
    always @(posedge i_clk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= 33);
    end

    // stop the run when no request or result moves for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("max_xor_pair_trie_tb failed");
            $finish;
        end
    end

    // one request, with a random gap in front; tvalid stays up into the next request
    task automatic send_value(input logic [VALUE_BITS-1:0] v, input logic first);
        int gap;
        gap = ($urandom_range(19) == 0) ? $urandom_range(90, 1) : 0;
        while (idle_on && (gap > 0 || $urandom_range(99) < 33)) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
            if (gap > 0)
                gap--;
        end
        s_tdata  <= DW'(v);
        s_tuser  <= first;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        prev_val = v;
        sent++;
    endtask

    // hold off new requests until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                    set_len;
        int                    k;
        bit                    paused;
        logic                  first;
        logic [VALUE_BITS-1:0] val;
        logic [VALUE_BITS-1:0] base;

        paused = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty trie right after reset, no set start
        send_value(21'h155555, 1'b0);
        send_value(21'h0AAAAA, 1'b0);
        // extremes and a duplicate that needs no new node
        send_value(21'h000000, 1'b1);
        send_value(21'h1FFFFF, 1'b0);
        send_value(21'h1FFFFF, 1'b0);
        send_value(21'h000000, 1'b0);
        // single set items back to back
        send_value(21'h0F0F0F, 1'b1);
        send_value(21'h1F0F0F, 1'b1);
        // differences in the top and bottom bits, and one in a middle bit
        send_value(21'h100000, 1'b1);
        send_value(21'h000001, 1'b0);
        send_value(21'h100001, 1'b0);
        send_value(21'h000400, 1'b0);
        send_value(21'h000000, 1'b1);
        send_value(21'h000001, 1'b0);
        send_value(21'h000002, 1'b0);
        send_value(21'h000003, 1'b0);
        drain_results();

        // random sets, mostly short, with related values to reach deep paths
        while (sent < RANDOM_ITEMS) begin
            idle_on <= !(sent >= 600 && sent < 900);
            if (!paused && sent >= 1000) begin
                drain_results();
                paused = 1'b1;
            end
            set_len = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(40, 1);
            base = VALUE_BITS'($urandom);
            for (k = 0; k < set_len; k++) begin
                case ($urandom_range(4))
                    0, 1:    val = VALUE_BITS'($urandom);
                    2:       val = base ^ (VALUE_BITS'(1) << $urandom_range(VALUE_BITS - 1));
                    3:       val = base ^ VALUE_BITS'($urandom_range(255));
                    default: val = prev_val;
                endcase
                // now and then a set runs on without a start flag
                first = (k == 0) && ($urandom_range(9) != 0);
                send_value(val, first);
            end
        end
        idle_on <= 1'b1;

        // close with one more short set
        send_value(21'h000000, 1'b1);
        send_value(21'h1FFFFF, 1'b0);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && waiting == 0)
            $display("max_xor_pair_trie_tb passed");
        else
            $display("max_xor_pair_trie_tb failed");
        $finish;
    end

endmodule
